// ===== src/fractional_area_image_binner_macros.svh =====
// Assertion macros for the fractional area image binner checker.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef FRACTIONAL_AREA_IMAGE_BINNER_MACROS_SVH
`define FRACTIONAL_AREA_IMAGE_BINNER_MACROS_SVH

// check a property outside reset
`define FAIB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge, reset included
`define FAIB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/faib_pkg.sv =====
// Types, constants and saturating helpers for the fractional area image binner.
// No dependencies.
package faib_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PIX_W     = 16;
   localparam int POS_W     = 29;
   localparam int ACC_W     = 44;
   localparam int SUM_W     = 56;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 12;
   localparam int ROWS_MAX  = 64;

   localparam logic [16:0]      UNIT     = 17'h10000;
   localparam logic [12:0]      SRC_MAX  = 13'd4096;
   localparam logic [6:0]       TROW_MAX = 7'd64;
   localparam logic [POS_W-1:0] EDGE_MAX = {POS_W{1'b1}};
   localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};

   typedef enum logic [2:0] {
      CSR_SRC_ROWS = 3'd0,
      CSR_SRC_COLS = 3'd1,
      CSR_DST_ROWS = 3'd2,
      CSR_DST_COLS = 3'd3,
      CSR_ROW_STEP = 3'd4,
      CSR_COL_STEP = 3'd5
   } csr_index_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CALC   = 8'b0000_0010,
      S_CMUL   = 8'b0000_0100,
      S_CWR    = 8'b0000_1000,
      S_COLEND = 8'b0001_0000,
      S_ERD    = 8'b0010_0000,
      S_ELOAD  = 8'b0100_0000,
      S_EWAIT  = 8'b1000_0000
   } state_type;

   function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] a,
                                                input logic [32:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {{(ACC_W-32){1'b0}}, b};
      return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
   endfunction

   function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W-ACC_W+1){1'b0}}, b};
      return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? EDGE_MAX : s[POS_W-1:0];
   endfunction

   function automatic logic [12:0] clamp_size(input logic [12:0] v,
                                              input logic [12:0] hi);
      return (v == 13'd0) ? 13'd1 : ((v > hi) ? hi : v);
   endfunction

endpackage

// ===== src/fractional_area_image_binner.sv =====
// Fractional area image binner: streaming column-major area downsampler.
// Depends on faib_pkg.
//
// Takes one source pixel per transfer, row index fastest, and bins the image
// to dst_rows x dst_cols target bins by exact fractional area, Q.16, with
// saturating sums. Bin sums of the open and next target columns live in two
// 64-entry banks of synchronous RAM that swap roles when a column closes; a
// per-entry valid bit stands for the cleared value, so reset needs no
// clearing pass. A pixel that crosses no row-bin edge and does not end a
// source column passes through an accept and an update state (S_IDLE,
// S_CALC). Each bin commit is a read-modify-write of the bank pair in
// S_CMUL and S_CWR, a column end adds S_COLEND, and a completed target
// column is sent out bin by bin through S_ERD, S_ELOAD and S_EWAIT plus any
// wait on rsp_ready. One pixel is in work at a time. Configuration is
// written with csr_we, csr_index and csr_wdata.
module fractional_area_image_binner (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [28:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [55:0] rsp_bin_sum,
   output logic [5:0]  rsp_target_row,
   output logic [11:0] rsp_target_col,
   output logic        rsp_column_done,
   output logic        rsp_frame_done
);

   localparam int AW = faib_pkg::ACC_W;
   localparam int SW = faib_pkg::SUM_W;
   localparam int PW = faib_pkg::POS_W;
   localparam int RN = faib_pkg::ROWS_MAX;

   // configuration
   logic [12:0]   src_rows_ff, src_cols_ff, dst_cols_ff;
   logic [6:0]    dst_rows_ff;
   logic [PW-1:0] row_step_ff, col_step_ff;

   // control state
   faib_pkg::state_type state_ff, state_in;
   logic [11:0]   row_cnt_ff, row_cnt_in, col_cnt_ff, col_cnt_in;
   logic [11:0]   tcol_ff, tcol_in;
   logic [5:0]    row_idx_ff, row_idx_in, emit_k_ff, emit_k_in;
   logic [AW-1:0] row_acc_ff, row_acc_in;
   logic [PW-1:0] row_edge_ff, row_edge_in, col_edge_ff, col_edge_in;
   logic          sel_ff, sel_in, tail_ff, tail_in, frame_end_ff, frame_end_in;
   logic [RN-1:0] vld0_ff, vld0_in, vld1_ff, vld1_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [15:0]   pixel_ff;
   logic          close_ff, close_in, col_end_ff, col_end_in;
   logic [16:0]   frac_ff, frac_in;
   logic [AW-1:0] w_ff, w_in, part_ff, part_in, rest_ff, rest_in;
   logic [5:0]    r_ff, r_in;
   logic [SW-1:0] rd0_ff, rd1_ff;
   logic [SW-1:0] bin_sum_ff, bin_sum_in;
   logic          last_ff, last_in;

   // bank memories
   logic [SW-1:0] bank0 [RN];
   logic [SW-1:0] bank1 [RN];
   logic [5:0]    raddr;
   logic          we0, we1;
   logic [SW-1:0] wd0, wd1;

   // clamped configuration
   logic [12:0]   sr, sc, dc;
   logic [6:0]    nrows;
   logic [PW-1:0] rs, cs;

   // datapath
   logic [PW-1:0] pix_start, pix_end, col_start, col_end_pos, col_cap, col_e;
   logic          row_hit, close_now, col_last, pix_col_end, frame_end_now;
   logic [16:0]   lo, a_now;
   logic [32:0]   prod_lo, prod_hi;
   logic [AW-1:0] acc_lo, acc_full;
   logic [44:0]   mf_hi;
   logic [32:0]   mf_lo;
   logic [AW-1:0] part_now;
   logic [SW-1:0] open_old, next_old, open_new, next_new;
   logic          emit_last;

   always_comb begin
      sr    = faib_pkg::clamp_size(src_rows_ff, faib_pkg::SRC_MAX);
      sc    = faib_pkg::clamp_size(src_cols_ff, faib_pkg::SRC_MAX);
      dc    = faib_pkg::clamp_size(dst_cols_ff, faib_pkg::SRC_MAX);
      nrows = (dst_rows_ff == 7'd0) ? 7'd1 :
              ((dst_rows_ff > faib_pkg::TROW_MAX) ? faib_pkg::TROW_MAX : dst_rows_ff);
      rs    = (row_step_ff < {12'd0, faib_pkg::UNIT}) ? {12'd0, faib_pkg::UNIT} : row_step_ff;
      cs    = (col_step_ff < {12'd0, faib_pkg::UNIT}) ? {12'd0, faib_pkg::UNIT} : col_step_ff;
   end

   // row binning of the current pixel
   always_comb begin
      pix_start = {1'b0, row_cnt_ff, 16'd0};
      pix_end   = pix_start + {12'd0, faib_pkg::UNIT};
      row_hit   = (({1'b0, row_idx_ff} + 7'd1) < nrows) && (row_edge_ff <= pix_end);
      lo        = (row_edge_ff > pix_start) ? 17'(row_edge_ff - pix_start) : 17'd0;
      prod_lo   = 33'(pixel_ff * lo);
      prod_hi   = 33'(pixel_ff * 17'(faib_pkg::UNIT - lo));
      acc_lo    = faib_pkg::sat_acc(row_acc_ff, prod_lo);
      acc_full  = faib_pkg::sat_acc(row_acc_ff, {1'b0, pixel_ff, 16'd0});
      pix_col_end   = !(({1'b0, row_cnt_ff} + 13'd1) < sr);
      frame_end_now = ({1'b0, col_cnt_ff} + 13'd1) >= sc;
   end

   // does the current source column close the open target column
   always_comb begin
      col_last    = (({1'b0, col_cnt_ff} + 13'd1) >= sc) || (({1'b0, tcol_ff} + 13'd1) >= dc);
      col_start   = {1'b0, col_cnt_ff, 16'd0};
      col_end_pos = col_start + {12'd0, faib_pkg::UNIT};
      col_cap     = {1'b0, 12'(sc - 13'd1), 16'd0};
      col_e       = (col_edge_ff < col_cap) ? col_edge_ff : col_cap;
      close_now   = !col_last && !(col_e > col_end_pos);
      a_now       = close_now ? ((col_e > col_start) ? 17'(col_e - col_start) : 17'd0)
                              : faib_pkg::UNIT;
   end

   // split of a row-bin value at the column edge
   always_comb begin
      mf_hi    = 45'(w_ff[AW-1:16] * frac_ff);
      mf_lo    = 33'(w_ff[15:0] * frac_ff);
      part_now = AW'(mf_hi + {28'd0, mf_lo[32:16]});
   end

   // read-modify-write of the bank pair
   always_comb begin
      if (sel_ff) begin
         open_old = vld1_ff[r_ff] ? rd1_ff : '0;
         next_old = vld0_ff[r_ff] ? rd0_ff : '0;
      end else begin
         open_old = vld0_ff[r_ff] ? rd0_ff : '0;
         next_old = vld1_ff[r_ff] ? rd1_ff : '0;
      end
      open_new = faib_pkg::sat_sum(open_old, part_ff);
      next_new = faib_pkg::sat_sum(next_old, rest_ff);
      we0   = (state_ff == faib_pkg::S_CWR) && (!sel_ff || close_ff);
      we1   = (state_ff == faib_pkg::S_CWR) && (sel_ff || close_ff);
      wd0   = sel_ff ? next_new : open_new;
      wd1   = sel_ff ? open_new : next_new;
      raddr = (state_ff == faib_pkg::S_CMUL) ? r_ff : emit_k_ff;
      emit_last = ({1'b0, emit_k_ff} + 7'd1) == nrows;
   end

   always_comb begin
      state_in     = state_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      tcol_in      = tcol_ff;
      row_idx_in   = row_idx_ff;
      emit_k_in    = emit_k_ff;
      row_acc_in   = row_acc_ff;
      row_edge_in  = row_edge_ff;
      col_edge_in  = col_edge_ff;
      sel_in       = sel_ff;
      tail_in      = tail_ff;
      frame_end_in = frame_end_ff;
      vld0_in      = vld0_ff;
      vld1_in      = vld1_ff;
      rsp_valid_in = rsp_valid_ff;
      close_in     = close_ff;
      col_end_in   = col_end_ff;
      frac_in      = frac_ff;
      w_in         = w_ff;
      r_in         = r_ff;
      part_in      = part_ff;
      rest_in      = rest_ff;
      bin_sum_in   = bin_sum_ff;
      last_in      = last_ff;

      unique case (state_ff)
         faib_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = faib_pkg::S_CALC;
            end
         end
         faib_pkg::S_CALC: begin
            close_in   = close_now;
            frac_in    = a_now;
            col_end_in = pix_col_end;
            if (!pix_col_end) begin
               row_cnt_in = row_cnt_ff + 12'd1;
            end
            if (row_hit) begin
               w_in        = acc_lo;
               r_in        = row_idx_ff;
               row_idx_in  = row_idx_ff + 6'd1;
               row_acc_in  = AW'(prod_hi);
               row_edge_in = faib_pkg::sat_pos(row_edge_ff, rs);
               tail_in     = pix_col_end;
               state_in    = faib_pkg::S_CMUL;
            end else begin
               row_acc_in = acc_full;
               w_in       = acc_full;
               r_in       = row_idx_ff;
               tail_in    = 1'b0;
               state_in   = pix_col_end ? faib_pkg::S_CMUL : faib_pkg::S_IDLE;
            end
         end
         faib_pkg::S_CMUL: begin
            part_in  = close_ff ? part_now : w_ff;
            rest_in  = close_ff ? (w_ff - part_now) : '0;
            state_in = faib_pkg::S_CWR;
         end
         faib_pkg::S_CWR: begin
            if (we0) begin
               vld0_in[r_ff] = 1'b1;
            end
            if (we1) begin
               vld1_in[r_ff] = 1'b1;
            end
            if (tail_ff) begin
               // commit the last row bin of the source column
               w_in     = row_acc_ff;
               r_in     = row_idx_ff;
               tail_in  = 1'b0;
               state_in = faib_pkg::S_CMUL;
            end else if (col_end_ff) begin
               state_in = faib_pkg::S_COLEND;
            end else begin
               state_in = faib_pkg::S_IDLE;
            end
         end
         faib_pkg::S_COLEND: begin
            row_cnt_in  = '0;
            row_idx_in  = '0;
            row_acc_in  = '0;
            row_edge_in = rs;
            emit_k_in   = '0;
            frame_end_in = frame_end_now;
            if (frame_end_now || close_ff) begin
               state_in = faib_pkg::S_ERD;
            end else begin
               col_cnt_in = col_cnt_ff + 12'd1;
               state_in   = faib_pkg::S_IDLE;
            end
         end
         faib_pkg::S_ERD: begin
            state_in = faib_pkg::S_ELOAD;
         end
         faib_pkg::S_ELOAD: begin
            if (sel_ff) begin
               bin_sum_in = vld1_ff[emit_k_ff] ? rd1_ff : '0;
            end else begin
               bin_sum_in = vld0_ff[emit_k_ff] ? rd0_ff : '0;
            end
            last_in      = emit_last;
            rsp_valid_in = 1'b1;
            state_in     = faib_pkg::S_EWAIT;
         end
         faib_pkg::S_EWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (!last_ff) begin
                  emit_k_in = emit_k_ff + 6'd1;
                  state_in  = faib_pkg::S_ERD;
               end else if (frame_end_ff) begin
                  vld0_in     = '0;
                  vld1_in     = '0;
                  tcol_in     = '0;
                  col_edge_in = cs;
                  col_cnt_in  = '0;
                  state_in    = faib_pkg::S_IDLE;
               end else begin
                  // drop the sent column, next bank becomes open
                  if (sel_ff) begin
                     vld1_in = '0;
                  end else begin
                     vld0_in = '0;
                  end
                  sel_in      = !sel_ff;
                  tcol_in     = tcol_ff + 12'd1;
                  col_edge_in = faib_pkg::sat_pos(col_edge_ff, cs);
                  col_cnt_in  = col_cnt_ff + 12'd1;
                  state_in    = faib_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = faib_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rows_ff <= 13'd1;
         src_cols_ff <= 13'd1;
         dst_rows_ff <= 7'd1;
         dst_cols_ff <= 13'd1;
         row_step_ff <= {12'd0, faib_pkg::UNIT};
         col_step_ff <= {12'd0, faib_pkg::UNIT};
      end else if (csr_we) begin
         case (csr_index)
            faib_pkg::CSR_SRC_ROWS: src_rows_ff <= csr_wdata[12:0];
            faib_pkg::CSR_SRC_COLS: src_cols_ff <= csr_wdata[12:0];
            faib_pkg::CSR_DST_ROWS: dst_rows_ff <= csr_wdata[6:0];
            faib_pkg::CSR_DST_COLS: dst_cols_ff <= csr_wdata[12:0];
            faib_pkg::CSR_ROW_STEP: row_step_ff <= csr_wdata;
            faib_pkg::CSR_COL_STEP: col_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= faib_pkg::S_IDLE;
         row_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         tcol_ff      <= '0;
         row_idx_ff   <= '0;
         emit_k_ff    <= '0;
         row_acc_ff   <= '0;
         row_edge_ff  <= {12'd0, faib_pkg::UNIT};
         col_edge_ff  <= {12'd0, faib_pkg::UNIT};
         sel_ff       <= 1'b0;
         tail_ff      <= 1'b0;
         frame_end_ff <= 1'b0;
         vld0_ff      <= '0;
         vld1_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         tcol_ff      <= tcol_in;
         row_idx_ff   <= row_idx_in;
         emit_k_ff    <= emit_k_in;
         row_acc_ff   <= row_acc_in;
         row_edge_ff  <= row_edge_in;
         col_edge_ff  <= col_edge_in;
         sel_ff       <= sel_in;
         tail_ff      <= tail_in;
         frame_end_ff <= frame_end_in;
         vld0_ff      <= vld0_in;
         vld1_ff      <= vld1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pixel_ff <= req_pixel;
      end
      close_ff   <= close_in;
      col_end_ff <= col_end_in;
      frac_ff    <= frac_in;
      w_ff       <= w_in;
      r_ff       <= r_in;
      part_ff    <= part_in;
      rest_ff    <= rest_in;
      bin_sum_ff <= bin_sum_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0[r_ff] <= wd0;
      end
      if (we1) begin
         bank1[r_ff] <= wd1;
      end
      rd0_ff <= bank0[raddr];
      rd1_ff <= bank1[raddr];
   end

   assign req_ready       = (state_ff == faib_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_sum     = bin_sum_ff;
   assign rsp_target_row  = emit_k_ff;
   assign rsp_target_col  = tcol_ff;
   assign rsp_column_done = last_ff;
   assign rsp_frame_done  = last_ff && frame_end_ff;

endmodule

// ===== src/faib_checker.sv =====
// Port-level checks for the fractional area image binner, bound to the top.
// Depends on fractional_area_image_binner_macros.svh.
`include "fractional_area_image_binner_macros.svh"

module faib_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [55:0] rsp_bin_sum,
   input logic [5:0]  rsp_target_row,
   input logic        rsp_column_done,
   input logic        rsp_frame_done
);

   // a pending result holds its payload
   `FAIB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_sum) && $stable(rsp_target_row), "result changed while stalled")
   `FAIB_ASSERT(a_frame_col, rsp_valid && rsp_frame_done |-> rsp_column_done, "frame end without column end")
   // no pixel is taken while a bin is being sent
   `FAIB_ASSERT(a_no_overlap, !(req_ready && rsp_valid), "pixel accepted during column output")
   `FAIB_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind fractional_area_image_binner faib_port_checker u_faib_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_bin_sum     (rsp_bin_sum),
   .rsp_target_row  (rsp_target_row),
   .rsp_column_done (rsp_column_done),
   .rsp_frame_done  (rsp_frame_done)
);
